/* design/qsu_pkg.sv */
// Shared types and character constants for the quoted string unescaper.
package qsu_pkg;

  localparam int unsigned OutDepth = 4;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_NORMAL = 3'd1,
    MODE_ESC    = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_HEX4   = 3'd4,
    MODE_OCT    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_CHAR = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  localparam logic [15:0] CH_SQUOTE = 16'h0027;
  localparam logic [15:0] CH_DQUOTE = 16'h0022;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_SLASH  = 16'h002F;
  localparam logic [15:0] CH_LC_B   = 16'h0062;
  localparam logic [15:0] CH_LC_F   = 16'h0066;
  localparam logic [15:0] CH_LC_N   = 16'h006E;
  localparam logic [15:0] CH_LC_R   = 16'h0072;
  localparam logic [15:0] CH_LC_T   = 16'h0074;
  localparam logic [15:0] CH_LC_X   = 16'h0078;
  localparam logic [15:0] CH_LC_U   = 16'h0075;
  localparam logic [15:0] CH_LC_A   = 16'h0061;
  localparam logic [15:0] CH_UC_A   = 16'h0041;
  localparam logic [15:0] CH_UC_F   = 16'h0046;
  localparam logic [15:0] CH_0      = 16'h0030;
  localparam logic [15:0] CH_3      = 16'h0033;
  localparam logic [15:0] CH_7      = 16'h0037;
  localparam logic [15:0] CH_9      = 16'h0039;

  localparam logic [15:0] VAL_BS  = 16'h0008;
  localparam logic [15:0] VAL_FF  = 16'h000C;
  localparam logic [15:0] VAL_LF  = 16'h000A;
  localparam logic [15:0] VAL_CR  = 16'h000D;
  localparam logic [15:0] VAL_TAB = 16'h0009;

  localparam logic [2:0] HEX2_NEED = 3'd2;
  localparam logic [2:0] HEX4_NEED = 3'd4;
  localparam logic [2:0] OCT_LONG  = 3'd3;
  localparam logic [2:0] OCT_SHORT = 3'd2;

  typedef struct packed {
    logic [15:0] ch;
    logic        last_char;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_char;
    status_e     status;
  } out_word_t;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] delimiter;
    logic [15:0] accumulator;
    logic [2:0]  digit_count;
    logic        octal_short;
  } dec_state_t;

  typedef struct packed {
    logic [1:0] count;
    out_word_t  w0;
    out_word_t  w1;
  } dec_results_t;

endpackage

/* design/quoted_string_unescaper_core.sv */
// Top level of the quoted string unescaper: string state register, decoder, result queue.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-----------------------------
//   in      | consumer  | in_valid_i / in_stall_o | ch[15:0], last_char
//   out     | producer  | out_valid_o / out_stall_i | out_char[15:0], status[1:0]
//
// One input word per cycle while in_stall_o is low. Each word is decoded in the cycle
// it is taken and its zero, one or two result words are registered in the result
// queue before they show at the output. The output side drains one word per cycle
// while out_stall_i is low, so the sustained rate is one input word per cycle, and
// words yielding two results (octal run end, char + completion) need a second word drained.
// Reset (async, active low) returns the string state to idle and empties the
// queue. Input stalls when fewer than two queue slots are free; out_stall_i
// simply holds the head word.
module quoted_string_unescaper_core #(
  parameter int unsigned FIFO_DEPTH = qsu_pkg::OutDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qsu_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qsu_pkg::out_word_t out_data_o
);
  import qsu_pkg::*;

  dec_state_t   state_q, state_d;
  dec_results_t dec_res;
  dec_results_t push;
  logic         accept;
  logic         almost_full;

  // take a word only when the queue can absorb the worst case of two results
  assign in_stall_o = almost_full;
  assign accept     = in_valid_i && !in_stall_o;

  qsu_decode u_decode (
    .cur_i (state_q),
    .in_i  (in_data_i),
    .nxt_o (state_d),
    .res_o (dec_res)
  );

  // nothing is queued unless the input word was really taken
  always_comb begin
    push = dec_res;
    if (!accept) push.count = 2'd0;
  end

  // string state: mode, delimiter, digit accumulator, digit count, short-octal flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: MODE_IDLE, delimiter: 16'd0, accumulator: 16'd0,
                   digit_count: 3'd0, octal_short: 1'b0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  qsu_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .almost_full_o (almost_full),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

/* design/qsu_decode.sv */
// Single-step character decoder: next string state and up to two result words.
module qsu_decode (
  input  qsu_pkg::dec_state_t   cur_i,
  input  qsu_pkg::in_word_t     in_i,
  output qsu_pkg::dec_state_t   nxt_o,
  output qsu_pkg::dec_results_t res_o
);
  import qsu_pkg::*;

  logic [15:0] c;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic        is_oct;
  logic [2:0]  cnt_inc;
  logic [2:0]  need;
  logic        err, done, as_normal;
  logic [1:0]  nch;
  logic [15:0] ch0, ch1;

  assign c       = in_i.ch;
  assign is_oct  = (c inside {[CH_0:CH_7]});
  assign cnt_inc = cur_i.digit_count + 3'd1;
  assign need    = (cur_i.mode == MODE_HEX2) ? HEX2_NEED : HEX4_NEED;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c inside {[CH_0:CH_9]}) begin
      hex_val = c[3:0];
    end else if ((c inside {[CH_UC_A:CH_UC_F]}) ||
                 (c inside {[CH_LC_A:CH_LC_A + 16'd5]})) begin
      // letters A-F / a-f: low nibble runs 1..6
      hex_val = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  // push one decoded character onto the two-slot list
  function automatic void push_ch(input logic [15:0] v, inout logic [1:0] n,
                                  inout logic [15:0] a, inout logic [15:0] b);
    if (n == 2'd0) a = v;
    else b = v;
    n = n + 2'd1;
  endfunction

  always_comb begin
    nxt_o     = cur_i;
    err       = 1'b0;
    done      = 1'b0;
    as_normal = 1'b0;
    nch       = 2'd0;
    ch0       = 16'd0;
    ch1       = 16'd0;

    case (cur_i.mode)
      MODE_IDLE: begin
        nxt_o.delimiter = c;
        nxt_o.mode      = MODE_NORMAL;
      end
      MODE_NORMAL: begin
        as_normal = 1'b1;
      end
      MODE_ESC: begin
        nxt_o.mode = MODE_NORMAL;
        if (c inside {CH_SQUOTE, CH_DQUOTE, CH_BSLASH, CH_SLASH}) begin
          push_ch(c, nch, ch0, ch1);
        end else if (c == CH_LC_B) begin
          push_ch(VAL_BS, nch, ch0, ch1);
        end else if (c == CH_LC_F) begin
          push_ch(VAL_FF, nch, ch0, ch1);
        end else if (c == CH_LC_N) begin
          push_ch(VAL_LF, nch, ch0, ch1);
        end else if (c == CH_LC_R) begin
          push_ch(VAL_CR, nch, ch0, ch1);
        end else if (c == CH_LC_T) begin
          push_ch(VAL_TAB, nch, ch0, ch1);
        end else if (c == CH_LC_X) begin
          nxt_o.mode        = MODE_HEX2;
          nxt_o.accumulator = 16'd0;
          nxt_o.digit_count = 3'd0;
        end else if (c == CH_LC_U) begin
          nxt_o.mode        = MODE_HEX4;
          nxt_o.accumulator = 16'd0;
          nxt_o.digit_count = 3'd0;
        end else if (is_oct) begin
          nxt_o.mode        = MODE_OCT;
          nxt_o.accumulator = {13'd0, c[2:0]};
          nxt_o.digit_count = 3'd1;
          nxt_o.octal_short = (c > CH_3);
        end else begin
          err = 1'b1;
        end
      end
      MODE_HEX2, MODE_HEX4: begin
        if (!hex_ok) begin
          err = 1'b1;
        end else begin
          nxt_o.accumulator = {cur_i.accumulator[11:0], hex_val};
          nxt_o.digit_count = cnt_inc;
          if (cnt_inc >= need) begin
            push_ch({8'd0, cur_i.accumulator[3:0], hex_val}, nch, ch0, ch1);
            nxt_o.mode = MODE_NORMAL;
          end
        end
      end
      MODE_OCT: begin
        if (is_oct) begin
          nxt_o.accumulator = {cur_i.accumulator[12:0], c[2:0]};
          nxt_o.digit_count = cnt_inc;
          if ((cnt_inc >= OCT_LONG) || ((cnt_inc >= OCT_SHORT) && cur_i.octal_short)) begin
            push_ch({8'd0, cur_i.accumulator[4:0], c[2:0]}, nch, ch0, ch1);
            nxt_o.mode = MODE_NORMAL;
          end
        end else begin
          // run ends: flush its value, then treat c as a plain string char
          push_ch({8'd0, cur_i.accumulator[7:0]}, nch, ch0, ch1);
          nxt_o.mode = MODE_NORMAL;
          as_normal  = 1'b1;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    if (as_normal && !err) begin
      if (c == cur_i.delimiter) begin
        done = 1'b1;
      end else if (c == CH_BSLASH) begin
        nxt_o.mode = MODE_ESC;
      end else begin
        push_ch(c, nch, ch0, ch1);
      end
    end

    if (!err && !done && in_i.last_char) err = 1'b1;

    if (err || done) begin
      nxt_o.mode        = MODE_IDLE;
      nxt_o.accumulator = 16'd0;
      nxt_o.digit_count = 3'd0;
      nxt_o.octal_short = 1'b0;
    end

    res_o.w0 = '{out_char: ch0, status: ST_CHAR};
    res_o.w1 = '{out_char: ch1, status: ST_CHAR};
    res_o.count = nch;
    if (err) begin
      res_o.count = 2'd1;
      res_o.w0    = '{out_char: 16'd0, status: ST_ERR};
    end else if (done) begin
      res_o.count = nch + 2'd1;
      if (nch == 2'd0) res_o.w0 = '{out_char: 16'd0, status: ST_DONE};
      else res_o.w1 = '{out_char: 16'd0, status: ST_DONE};
    end
  end

endmodule

/* design/qsu_out_fifo.sv */
// Result queue: up to two words written per cycle, one word read per cycle unless out_stall_i holds it.
module qsu_out_fifo #(
  parameter int unsigned DEPTH = qsu_pkg::OutDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qsu_pkg::dec_results_t push_i,
  output logic                  almost_full_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output qsu_pkg::out_word_t    out_data_o
);
  import qsu_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  out_word_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr1;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr1           = ptr_inc(wr_q);
  assign pop           = out_valid_o && !out_stall_i;
  assign out_valid_o   = (cnt_q != '0);
  assign out_data_o    = mem_q[rd_q];
  assign almost_full_o = (cnt_q > CntW'(DEPTH - 2));

  always_comb begin
    case (push_i.count)
      2'd0:    wr_d = wr_q;
      2'd1:    wr_d = wr1;
      default: wr_d = ptr_inc(wr1);
    endcase
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.w0;
    if (push_i.count >= 2'd2) mem_q[wr1] <= push_i.w1;
  end

endmodule

/* tb/sv/quoted_string_unescaper_core_tb.sv */
// Self-checking testbench for quoted_string_unescaper_core: directed and random strings.
module quoted_string_unescaper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qsu_pkg::*;

  // Run sizing
  localparam int unsigned RANDOM_CHARS = 950;   // random characters after the directed tests
  localparam int unsigned QUIET_FROM   = 350;   // random stretch with no idling on either side
  localparam int unsigned QUIET_TO     = 650;
  localparam int unsigned IDLE_PCT     = 27;    // idle / stall probability per cycle
  localparam int unsigned HOLD_CYCLES  = 60;    // long output hold-off
  localparam int unsigned PRESSURE_LEN = 24;    // characters offered during the hold-off
  localparam int unsigned DRAIN_CYCLES = 16;    // quiet cycles after the last result
  localparam int unsigned LIMIT_CYCLES = 100000;
  localparam int unsigned MAX_REPORTS  = 40;

  // Characters that name no escape or no hex digit
  localparam logic [15:0] CH_LC_G = 16'h0067;
  localparam logic [15:0] CH_LC_Q = 16'h0071;
  localparam logic [15:0] CH_8    = 16'h0038;
  localparam logic [15:0] CH_MAX  = 16'hFFFF;
  localparam logic [15:0] CH_NUL  = 16'h0000;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  quoted_string_unescaper_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Decoder state as the testbench sees it
  mode_e       str_mode;
  logic [15:0] str_delim;
  logic [15:0] str_acc;
  logic [2:0]  str_digits;
  logic        str_short;

  out_word_t   pending_results[$];  // result words still owed by the block
  logic [15:0] text_buf[$];         // characters of the string being built

  bit src_idle_en;
  bit sink_idle_en;
  bit sink_hold;

  int unsigned chars_fed;
  int unsigned strings_fed;
  int unsigned words_checked;
  int unsigned mismatches;
  int unsigned cycle_count;

  event hold_start;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int hex_digit(input logic [15:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
    if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
    return -1;
  endfunction

  // The delimiter survives the return to idle; the next string overwrites it.
  task automatic clear_string_state();
    str_mode   = MODE_IDLE;
    str_acc    = '0;
    str_digits = '0;
    str_short  = 1'b0;
  endtask

  task automatic queue_result(input logic [15:0] c, input status_e st);
    out_word_t r;
    r.out_char = c;
    r.status   = st;
    pending_results.push_back(r);
  endtask

  // Advances the string state by one accepted character and queues its results.
  task automatic decode_char(input in_word_t w);
    logic [15:0] c;
    logic [15:0] decoded[2];
    int          n_dec;
    int          hv;
    logic [2:0]  need;
    bit          fail;
    bit          done;
    bit          plain;
    c     = w.ch;
    n_dec = 0;
    fail  = 1'b0;
    done  = 1'b0;
    plain = 1'b0;
    case (str_mode)
      MODE_IDLE: begin
        str_delim = c;
        str_mode  = MODE_NORMAL;
      end
      MODE_NORMAL: plain = 1'b1;
      MODE_ESC: begin
        str_mode = MODE_NORMAL;
        if (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BSLASH || c == CH_SLASH) begin
          decoded[n_dec] = c;
          n_dec++;
        end else if (c == CH_LC_B) begin
          decoded[n_dec] = VAL_BS;
          n_dec++;
        end else if (c == CH_LC_F) begin
          decoded[n_dec] = VAL_FF;
          n_dec++;
        end else if (c == CH_LC_N) begin
          decoded[n_dec] = VAL_LF;
          n_dec++;
        end else if (c == CH_LC_R) begin
          decoded[n_dec] = VAL_CR;
          n_dec++;
        end else if (c == CH_LC_T) begin
          decoded[n_dec] = VAL_TAB;
          n_dec++;
        end else if (c == CH_LC_X || c == CH_LC_U) begin
          str_mode   = (c == CH_LC_X) ? MODE_HEX2 : MODE_HEX4;
          str_acc    = '0;
          str_digits = '0;
        end else if (c >= CH_0 && c <= CH_7) begin
          str_mode   = MODE_OCT;
          str_acc    = c - CH_0;
          str_digits = 3'd1;
          str_short  = (c > CH_3);
        end else begin
          fail = 1'b1;
        end
      end
      MODE_HEX2, MODE_HEX4: begin
        hv   = hex_digit(c);
        need = (str_mode == MODE_HEX2) ? HEX2_NEED : HEX4_NEED;
        if (hv < 0) begin
          fail = 1'b1;
        end else begin
          str_acc    = {str_acc[11:0], hv[3:0]};
          str_digits = str_digits + 3'd1;
          if (str_digits >= need) begin
            decoded[n_dec] = {8'h00, str_acc[7:0]};
            n_dec++;
            str_mode = MODE_NORMAL;
          end
        end
      end
      MODE_OCT: begin
        if (c >= CH_0 && c <= CH_7) begin
          str_acc    = {str_acc[12:0], c[2:0]};
          str_digits = str_digits + 3'd1;
          if (str_digits >= OCT_LONG || (str_digits >= OCT_SHORT && str_short)) begin
            decoded[n_dec] = {8'h00, str_acc[7:0]};
            n_dec++;
            str_mode = MODE_NORMAL;
          end
        end else begin
          // run ends: emit its value, then treat c as a plain string character
          decoded[n_dec] = {8'h00, str_acc[7:0]};
          n_dec++;
          str_mode = MODE_NORMAL;
          plain    = 1'b1;
        end
      end
      default: begin
        clear_string_state();
        fail = 1'b1;
      end
    endcase

    if (plain && !fail) begin
      if (c == str_delim) begin
        done = 1'b1;
      end else if (c == CH_BSLASH) begin
        str_mode = MODE_ESC;
      end else begin
        decoded[n_dec] = c;
        n_dec++;
      end
    end

    // end of buffer with the string still open
    if (!fail && !done && w.last_char) fail = 1'b1;

    if (fail) begin
      // anything decoded in this step is dropped with the string
      clear_string_state();
      queue_result('0, ST_ERR);
    end else begin
      for (int k = 0; k < n_dec; k++) queue_result(decoded[k], ST_CHAR);
      if (done) begin
        clear_string_state();
        queue_result('0, ST_DONE);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one word from a falling edge and returns at the falling edge after
  // it is taken. Valid stays high between back-to-back words.
  task automatic feed_char(input logic [15:0] c, input logic is_last);
    in_word_t w;
    w.ch        = c;
    w.last_char = is_last;
    while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    decode_char(w);
    chars_fed++;
    @(negedge clk_i);
  endtask

  task automatic feed_buffer(input bit end_flag);
    int last_idx;
    last_idx = text_buf.size() - 1;
    for (int i = 0; i <= last_idx; i++) feed_char(text_buf[i], end_flag && (i == last_idx));
    strings_fed++;
  endtask

  task automatic add_escape(input logic [15:0] c);
    text_buf.push_back(CH_BSLASH);
    text_buf.push_back(c);
  endtask

  function automatic logic [15:0] simple_escape(input int idx);
    case (idx)
      0:       return CH_SQUOTE;
      1:       return CH_DQUOTE;
      2:       return CH_BSLASH;
      3:       return CH_SLASH;
      4:       return CH_LC_B;
      5:       return CH_LC_F;
      6:       return CH_LC_N;
      7:       return CH_LC_R;
      default: return CH_LC_T;
    endcase
  endfunction

  function automatic logic [15:0] random_hex_digit();
    int v;
    v = $urandom_range(21);
    if (v < 10) return CH_0 + 16'(v);
    if (v < 16) return CH_LC_A + 16'(v - 10);
    return CH_UC_A + 16'(v - 16);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Long hold-off, counted here so the sender keeps offering words meanwhile.
  always begin
    @(hold_start);
    @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= sink_hold || (sink_idle_en && $urandom_range(99) < IDLE_PCT);
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // Every word taken from the output is checked against the oldest one owed.
  always @(posedge clk_i) begin : check_result
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing owed", out_data_o.out_char, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", 16'(out_data_o.status), 16'(want.status));
        if (out_data_o.out_char !== want.out_char)
          report_mismatch("out_char", out_data_o.out_char, want.out_char);
        words_checked++;
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still owed",
             cycle_count, pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero and all-ones characters as content, all-ones also as delimiter.
  task automatic test_extremes();
    text_buf.delete();
    text_buf.push_back(CH_DQUOTE);
    text_buf.push_back(CH_NUL);
    text_buf.push_back(CH_MAX);
    text_buf.push_back(CH_DQUOTE);
    feed_buffer(1'b0);
    text_buf.delete();
    text_buf.push_back(CH_MAX);
    text_buf.push_back(16'h8000);
    text_buf.push_back(16'h7FFF);
    text_buf.push_back(CH_MAX);
    feed_buffer(1'b1);  // closing delimiter on the last word still completes
  endtask

  // All single-character escapes; slash is the delimiter, so the escaped
  // delimiter decodes to itself.
  task automatic test_simple_escapes();
    text_buf.delete();
    text_buf.push_back(CH_SLASH);
    for (int i = 0; i < 9; i++) add_escape(simple_escape(i));
    text_buf.push_back(CH_SLASH);
    feed_buffer(1'b0);
  endtask

  // Hex, unicode and octal, including short octal, a run cut off by a plain
  // character and one cut off by the closing delimiter (two results).
  task automatic test_numeric_escapes();
    text_buf.delete();
    text_buf.push_back(CH_SQUOTE);
    add_escape(CH_LC_X);
    text_buf.push_back(CH_UC_F);
    text_buf.push_back(CH_LC_F);
    add_escape(CH_LC_U);
    text_buf.push_back(CH_0 + 16'd1);
    text_buf.push_back(CH_0 + 16'd2);
    text_buf.push_back(CH_LC_A);
    text_buf.push_back(CH_UC_A + 16'd1);
    add_escape(CH_0 + 16'd3);
    text_buf.push_back(CH_7);
    text_buf.push_back(CH_7);
    add_escape(CH_0 + 16'd4);
    text_buf.push_back(CH_0 + 16'd5);
    add_escape(CH_7);
    text_buf.push_back(CH_UC_A);
    add_escape(CH_0);
    text_buf.push_back(CH_SQUOTE);
    feed_buffer(1'b0);
  endtask

  task automatic test_error_endings();
    // bad escape
    text_buf.delete();
    text_buf.push_back(CH_DQUOTE);
    text_buf.push_back(CH_LC_A);
    add_escape(CH_LC_Q);
    feed_buffer(1'b0);
    // delimiter inside a hex escape is a bad digit
    text_buf.delete();
    text_buf.push_back(CH_DQUOTE);
    add_escape(CH_LC_X);
    text_buf.push_back(CH_UC_F);
    text_buf.push_back(CH_DQUOTE);
    feed_buffer(1'b0);
    // bad unicode digit
    text_buf.delete();
    text_buf.push_back(CH_DQUOTE);
    add_escape(CH_LC_U);
    text_buf.push_back(CH_0 + 16'd1);
    text_buf.push_back(CH_LC_G);
    feed_buffer(1'b0);
    // buffer ends on the opening delimiter
    text_buf.delete();
    text_buf.push_back(CH_DQUOTE);
    feed_buffer(1'b1);
    // buffer ends while an octal run resolves into two characters: error only
    text_buf.delete();
    text_buf.push_back(CH_DQUOTE);
    add_escape(CH_0 + 16'd5);
    text_buf.push_back(CH_LC_A);
    feed_buffer(1'b1);
  endtask

  // Output held off for a long stretch while input keeps coming.
  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    text_buf.delete();
    text_buf.push_back(CH_DQUOTE);
    repeat (PRESSURE_LEN) text_buf.push_back(CH_LC_A + 16'($urandom_range(25)));
    add_escape(CH_LC_N);
    text_buf.push_back(CH_DQUOTE);
    -> hold_start;
    feed_buffer(1'b0);
  endtask

  // Builds one random string, mostly well formed, sometimes broken.
  task automatic build_random_string(output bit end_flag);
    logic [15:0] delim;
    logic [15:0] c;
    int          kind;
    int          n;
    text_buf.delete();
    end_flag = 1'b0;
    case ($urandom_range(3))
      0:       delim = CH_DQUOTE;
      1:       delim = CH_SQUOTE;
      default: delim = 16'($urandom);
    endcase
    text_buf.push_back(delim);
    repeat ($urandom_range(10)) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        c = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(16'h20, 16'h7E));
        text_buf.push_back(c);
      end else if (kind < 60) begin
        add_escape(simple_escape($urandom_range(8)));
      end else if (kind < 70) begin
        add_escape(CH_LC_X);
        repeat (2) text_buf.push_back(random_hex_digit());
      end else if (kind < 80) begin
        add_escape(CH_LC_U);
        repeat (4) text_buf.push_back(random_hex_digit());
      end else if (kind < 92) begin
        add_escape(CH_0 + 16'($urandom_range(7)));
        repeat ($urandom_range(2)) text_buf.push_back(CH_0 + 16'($urandom_range(7)));
      end else if (kind < 95) begin
        add_escape(delim);
      end else begin
        text_buf.push_back(16'($urandom));
      end
    end
    kind = $urandom_range(99);
    if (kind < 86) begin
      text_buf.push_back(delim);
      end_flag = ($urandom_range(9) == 0);
    end else if (kind < 91) begin
      end_flag = 1'b1;  // truncated string
    end else if (kind < 95) begin
      case ($urandom_range(3))
        0:       add_escape(CH_LC_Q);
        1:       add_escape(CH_8);
        2:       add_escape(CH_NUL);
        default: add_escape(CH_MAX);
      endcase
    end else begin
      n = $urandom_range(1) ? 1 : 3;
      add_escape((n == 1) ? CH_LC_X : CH_LC_U);
      repeat ($urandom_range(n)) text_buf.push_back(random_hex_digit());
      text_buf.push_back($urandom_range(1) ? CH_LC_G : CH_MAX);
    end
  endtask

  task automatic test_random_strings();
    int unsigned start;
    bit          end_flag;
    bit          quiet;
    start = chars_fed;
    while (chars_fed - start < RANDOM_CHARS) begin
      quiet        = (chars_fed - start >= QUIET_FROM) && (chars_fed - start < QUIET_TO);
      src_idle_en  = !quiet;
      sink_idle_en = !quiet;
      build_random_string(end_flag);
      feed_buffer(end_flag);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    chars_fed     = 0;
    strings_fed   = 0;
    words_checked = 0;
    mismatches    = 0;
    str_delim     = '0;
    clear_string_state();

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_simple_escapes();
    test_numeric_escapes();
    test_error_endings();
    test_backpressure();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    test_random_strings();

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Fed %0d strings (%0d characters) incl. escapes, numeric runs, error endings,",
             strings_fed, chars_fed);
    $display("an output hold-off and idle-free stretches; %0d result words checked, %0d bad.",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
